// ----- rtl/sobel_gradient_magnitude_direction_core_macros.svh -----
// assertion helpers for the sobel gradient core
`ifndef SOBEL_GRADIENT_MAGNITUDE_DIRECTION_CORE_MACROS_SVH
`define SOBEL_GRADIENT_MAGNITUDE_DIRECTION_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SGMD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define SGMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SGMD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define SGMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/sgmd_pkg.sv -----
`timescale 1ns / 1ps
package sgmd_pkg;

    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [10:0] WIDTH_RESET  = 11'd640;
    localparam logic [11:0] HEIGHT_RESET = 12'd480;

    localparam logic [1:0] DIR_HORIZ = 2'd0;
    localparam logic [1:0] DIR_MINUS = 2'd1;
    localparam logic [1:0] DIR_PLUS  = 2'd2;
    localparam logic [1:0] DIR_VERT  = 2'd3;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] magnitude;
        logic [1:0] direction;
        logic       frame_last;
    } t_grad_out;

    typedef struct packed {
        logic signed [10:0] gx;
        logic signed [10:0] gy;
        logic               last;
    } t_grad;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SUM,
        B_SQRT,
        B_OUT
    } t_back_state;

endpackage

// ----- rtl/sgmd_front.sv -----
`timescale 1ns / 1ps
module sgmd_front import sgmd_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_pix_in     i_in_data,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [11:0] i_cfg_data,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_grad       o_q_data
);
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [10:0]   r_width;
    logic [11:0]   r_height;
    logic [CW-1:0] r_col;
    logic [11:0]   r_row;
    logic          r_busy;
    logic [CW-1:0] r_c;
    logic [7:0]    r_pix;
    logic          r_emit;
    logic          r_last;
    logic [7:0]    r_top;
    logic [7:0]    r_mid;
    logic [7:0]    r_win [9];

    logic [7:0] mem_above [MAX_WIDTH];
    logic [7:0] mem_middle [MAX_WIDTH];

    logic [WW-1:0] w_use;
    logic [11:0]   h_use;
    logic [WW-1:0] c_cur, c_nxt;
    logic [11:0]   row_cur, row_nxt;
    logic          accept;
    logic [9:0]    gy_pos, gy_neg, gx_pos, gx_neg;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = r_busy || i_q_full;

    always_comb begin
        if (32'(r_width) > MAX_WIDTH) begin
            w_use = WW'(MAX_WIDTH);
        end else if (r_width < 11'd3) begin
            w_use = WW'(3);
        end else begin
            w_use = WW'(r_width);
        end
        h_use = (r_height < 12'd3) ? 12'd3 : r_height;

        c_cur   = WW'(r_col);
        row_cur = r_row;
        if (i_in_data.frame_start) begin
            c_cur   = '0;
            row_cur = '0;
        end
        if (c_cur >= w_use) begin
            c_cur   = '0;
            row_cur = row_cur + 12'd1;
        end
        if (row_cur >= h_use) begin
            row_cur = '0;
        end
        c_nxt   = c_cur + WW'(1);
        row_nxt = row_cur;
        if (c_nxt >= w_use) begin
            c_nxt   = '0;
            row_nxt = row_cur + 12'd1;
            if (row_nxt >= h_use) begin
                row_nxt = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_col    <= '0;
            r_row    <= '0;
            r_busy   <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_IMAGE_WIDTH) begin
                    r_width <= i_cfg_data[10:0];
                end else begin
                    r_height <= i_cfg_data;
                end
            end
            if (accept) begin
                r_col  <= c_nxt[CW-1:0];
                r_row  <= row_nxt;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_busy <= 1'b0;
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
                r_win[2] <= r_top;
                r_win[3] <= r_win[4];
                r_win[4] <= r_win[5];
                r_win[5] <= r_mid;
                r_win[6] <= r_win[7];
                r_win[7] <= r_win[8];
                r_win[8] <= r_pix;
            end
        end
    end

    // payload of the word in flight
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_c    <= c_cur[CW-1:0];
            r_pix  <= i_in_data.pixel;
            r_emit <= (row_cur >= 12'd2) && (c_cur >= WW'(2));
            r_last <= (row_cur == h_use - 12'd1) && (c_cur == w_use - WW'(1));
        end
    end

    // line buffers: read on accept, written back in the following cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_top <= mem_above[c_cur[CW-1:0]];
            r_mid <= mem_middle[c_cur[CW-1:0]];
        end
        if (r_busy) begin
            mem_above[r_c]  <= r_mid;
            mem_middle[r_c] <= r_pix;
        end
    end

    // gradients on the window after this shift
    always_comb begin
        gy_pos = 10'(r_win[1]) + {1'b0, r_win[2], 1'b0} + 10'(r_top);
        gy_neg = 10'(r_win[7]) + {1'b0, r_win[8], 1'b0} + 10'(r_pix);
        gx_pos = 10'(r_top) + {1'b0, r_mid, 1'b0} + 10'(r_pix);
        gx_neg = 10'(r_win[1]) + {1'b0, r_win[4], 1'b0} + 10'(r_win[7]);
    end

    assign o_q_push      = r_busy && r_emit;
    assign o_q_data.gx   = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
    assign o_q_data.gy   = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
    assign o_q_data.last = r_last;

endmodule

// ----- rtl/sgmd_queue.sv -----
`timescale 1ns / 1ps
module sgmd_queue import sgmd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_grad i_data,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_grad o_data
);
    t_grad      r_ent [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_data;
        end
    end

endmodule

// ----- rtl/sgmd_back.sv -----
`timescale 1ns / 1ps
`include "sobel_gradient_magnitude_direction_core_macros.svh"
module sgmd_back import sgmd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_grad     i_q_data,
    output logic      o_q_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_grad_out o_out_data
);
    t_back_state r_state, n_state;
    logic [20:0] r_gx2, r_gy2;
    logic [21:0] r_s2;
    logic [19:0] r_d2, r_ax2;
    logic        r_ay_gt, r_gx_zero, r_neg, r_last;
    logic [21:0] r_v;
    logic [1:0]  r_dir;
    logic [7:0]  r_root;
    logic [2:0]  r_idx;
    logic        r_ovalid;
    t_grad_out   r_out;

    logic [9:0]  ax, ay;
    logic [10:0] s_ax_ay;
    logic [9:0]  d_ay_ax;
    logic [19:0] ax_sq, ay_sq, d_sq;
    logic [21:0] s_sq;
    logic [21:0] sum_v;
    logic [1:0]  dir;
    logic [7:0]  t_try;
    logic [15:0] t_sq;
    logic        out_free;

    assign out_free = !r_ovalid || !i_out_stall;
    assign o_q_pop  = (r_state == B_IDLE) && i_q_valid;

    always_comb begin
        ax      = i_q_data.gx[10] ? 10'(-i_q_data.gx) : i_q_data.gx[9:0];
        ay      = i_q_data.gy[10] ? 10'(-i_q_data.gy) : i_q_data.gy[9:0];
        s_ax_ay = 11'(ax) + 11'(ay);
        d_ay_ax = ay - ax;
        // squares of magnitudes, operands widened to the product width
        ax_sq   = 20'(ax) * 20'(ax);
        ay_sq   = 20'(ay) * 20'(ay);
        d_sq    = 20'(d_ay_ax) * 20'(d_ay_ax);
        s_sq    = 22'(s_ax_ay) * 22'(s_ax_ay);
    end

    always_comb begin
        sum_v = 22'(r_gx2) + 22'(r_gy2);
        if (r_gx_zero) begin
            dir = DIR_VERT;
        end else if (r_s2 < {1'b0, r_ax2, 1'b0}) begin
            dir = DIR_HORIZ;
        end else if (r_ay_gt && ({1'b0, r_d2} > {r_ax2, 1'b0})) begin
            dir = DIR_VERT;
        end else begin
            dir = r_neg ? DIR_MINUS : DIR_PLUS;
        end
        t_try = r_root | (8'd1 << r_idx);
        t_sq  = t_try * t_try;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (i_q_valid) n_state = B_SUM;
            B_SUM:  n_state = (sum_v >= 22'd65536) ? B_OUT : B_SQRT;
            B_SQRT: if (r_idx == 3'd0) n_state = B_OUT;
            B_OUT:  if (out_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_gx2     <= 21'(ax_sq);
                r_gy2     <= 21'(ay_sq);
                r_s2      <= s_sq;
                r_d2      <= d_sq;
                r_ax2     <= ax_sq;
                r_ay_gt   <= ay > ax;
                r_gx_zero <= i_q_data.gx == '0;
                r_neg     <= (i_q_data.gy != '0) && (i_q_data.gx[10] != i_q_data.gy[10]);
                r_last    <= i_q_data.last;
            end
            B_SUM: begin
                r_v    <= sum_v;
                r_dir  <= dir;
                r_idx  <= 3'd7;
                r_root <= (sum_v >= 22'd65536) ? 8'd255 : 8'd0;
            end
            // one result bit per cycle, msb first
            B_SQRT: begin
                if (22'(t_sq) <= r_v) begin
                    r_root <= t_try;
                end
                r_idx <= r_idx - 3'd1;
            end
            B_OUT: begin
                if (out_free) begin
                    r_out.magnitude  <= r_root;
                    r_out.direction  <= r_dir;
                    r_out.frame_last <= r_last;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    `SGMD_ASSERT_NEXT(a_out_loads, i_clk, i_rst_n, r_state == B_OUT && !r_ovalid, r_ovalid, "result not loaded")
    `SGMD_ASSERT_NEXT(a_sqrt_ends, i_clk, i_rst_n, r_state == B_SQRT && r_idx == 3'd0, r_state == B_OUT, "root did not finish")
    `SGMD_ASSERT_SAME(a_sqrt_range, i_clk, i_rst_n, r_state == B_SQRT, r_v < 22'd65536, "saturated value entered root")

endmodule

// ----- rtl/sobel_gradient_magnitude_direction_core.sv -----
`timescale 1ns / 1ps
// path from input accept to the result word on the output register: front write back,
// queue read, setup, 8 root steps (none when the root saturates), load
// the front takes a new pixel only once the line buffer write back of the last one is done;
// interior pixels are further limited by the bit-serial square root, which takes no new
// gradient until the last result is loaded, and by output stalls
// reset: synchronous active low, counters and window cleared, width 640, height 480
module sobel_gradient_magnitude_direction_core import sgmd_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_pix_in     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_grad_out   o_out_data,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [11:0] i_cfg_data
);
    logic  q_full, q_push, q_pop, q_valid;
    t_grad q_in, q_out;

    sgmd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_in)
    );

    sgmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    sgmd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_out),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- tb/tb_sobel_gradient_magnitude_direction_core.sv -----
`timescale 1ns / 1ps
module tb_sobel_gradient_magnitude_direction_core;
    import sgmd_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_pix_in     in_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_grad_out   out_word;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = CFG_IMAGE_WIDTH;
    logic [11:0] cfg_data = '0;

    sobel_gradient_magnitude_direction_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    t_pix_in   pixel_q[$];
    t_grad_out grad_q[$];
    int        tx_idle_pct = 0;
    int        rx_stall_pct = 0;
    int        rx_hold_cycles = 0;
    int        mismatches = 0;

    // shadow of the block: line buffers, window, raster position, sizes
    logic [7:0]  line_above[1024];
    logic [7:0]  line_mid[1024];
    logic [7:0]  win[9];
    int          col_pos = 0;
    int          row_pos = 0;
    logic [10:0] width_reg = WIDTH_RESET;
    logic [11:0] height_reg = HEIGHT_RESET;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] root_sat(int v);
        int r;
        r = 0;
        if (v >= 65536) return 8'd255;
        for (int b = 128; b != 0; b = b >> 1) begin
            if ((r | b) * (r | b) <= v) r = r | b;
        end
        return r[7:0];
    endfunction

    function automatic logic [1:0] grad_sector(int gx, int gy);
        int ax, ay, d;
        if (gx == 0) return DIR_VERT;
        ax = gx < 0 ? -gx : gx;
        ay = gy < 0 ? -gy : gy;
        // tan 22.5 = sqrt2 - 1, tan 67.5 = sqrt2 + 1, compared squared
        if ((ay + ax) * (ay + ax) < 2 * ax * ax) return DIR_HORIZ;
        if (ay > ax) begin
            d = ay - ax;
            if (d * d > 2 * ax * ax) return DIR_VERT;
        end
        if (gy != 0 && ((gx < 0) != (gy < 0))) return DIR_MINUS;
        return DIR_PLUS;
    endfunction

    function automatic void predict_gradient(t_pix_in px);
        int w, h, gx, gy;
        logic [7:0] top, mid;
        t_grad_out g;
        w = width_reg;
        h = height_reg;
        if (w < 3) w = 3;
        if (w > 1024) w = 1024;
        if (h < 3) h = 3;
        if (px.frame_start) begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        top = line_above[col_pos];
        mid = line_mid[col_pos];
        line_above[col_pos] = mid;
        line_mid[col_pos] = px.pixel;
        for (int k = 0; k < 3; k++) begin
            win[3*k] = win[3*k+1];
            win[3*k+1] = win[3*k+2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = px.pixel;
        if (row_pos >= 2 && col_pos >= 2) begin
            gy = int'(win[0]) + 2 * int'(win[1]) + int'(win[2])
               - int'(win[6]) - 2 * int'(win[7]) - int'(win[8]);
            gx = int'(win[2]) + 2 * int'(win[5]) + int'(win[8])
               - int'(win[0]) - 2 * int'(win[3]) - int'(win[6]);
            g.magnitude = root_sat(gx * gx + gy * gy);
            g.direction = grad_sector(gx, gy);
            g.frame_last = (row_pos == h - 1 && col_pos == w - 1);
            grad_q.push_back(g);
        end
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_word <= '0;
        end else begin
            if (in_valid && !in_stall) predict_gradient(in_word);
            if (!in_valid || !in_stall) begin
                if (pixel_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    in_word <= pixel_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (rx_hold_cycles > 0) rx_hold_cycles <= rx_hold_cycles - 1;
    end

    // monitor
    always @(posedge i_clk) begin
        t_grad_out exp_w;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (grad_q.size() == 0) begin
                    $error("unexpected word: %p", out_word);
                    mismatches++;
                end else begin
                    exp_w = grad_q.pop_front();
                    if (out_word.magnitude !== exp_w.magnitude) begin
                        $error("magnitude: expected %0d, got %0d",
                               exp_w.magnitude, out_word.magnitude);
                        mismatches++;
                    end
                    if (out_word.direction !== exp_w.direction) begin
                        $error("direction: expected %0d, got %0d",
                               exp_w.direction, out_word.direction);
                        mismatches++;
                    end
                    if (out_word.frame_last !== exp_w.frame_last) begin
                        $error("frame_last: expected %0d, got %0d",
                               exp_w.frame_last, out_word.frame_last);
                        mismatches++;
                    end
                end
            end
            out_stall <= (rx_hold_cycles > 0) || ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    task automatic write_reg(logic idx, logic [11:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        if (idx == CFG_IMAGE_WIDTH) width_reg = val[10:0];
        else height_reg = val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pixel_q.size() > 0 || in_valid || grad_q.size() > 0) @(posedge i_clk);
        // pixels that produce no word may still be in the window front
        repeat (30) @(posedge i_clk);
    endtask

    task automatic push_pixel(logic [7:0] v, logic fs);
        t_pix_in p;
        p.pixel = v;
        p.frame_start = fs;
        pixel_q.push_back(p);
    endtask

    task automatic push_random(int n, int binary_pct, int fs_pct);
        logic [7:0] v;
        for (int i = 0; i < n; i++) begin
            v = $urandom_range(0, 99) < binary_pct ? ($urandom_range(0, 1) ? 8'hff : 8'h00)
                                                   : 8'($urandom);
            push_pixel(v, $urandom_range(0, 99) < fs_pct);
        end
    endtask

    task automatic push_frames(int w, int h, int n);
        int cnt;
        cnt = 0;
        while (cnt < n) begin
            // some frames rely on the automatic wrap instead of frame_start
            push_pixel(8'($urandom), $urandom_range(0, 3) != 0);
            push_random(w * h - 1, 30, 1);
            cnt += w * h;
        end
    endtask

    initial begin
        int w, h;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // wide frame first so every line buffer entry used later gets written
        write_reg(CFG_IMAGE_WIDTH, 12'd96);
        write_reg(CFG_IMAGE_HEIGHT, 12'd3);
        push_pixel(8'($urandom), 1'b1);
        push_random(287, 20, 0);
        drain();

        write_reg(CFG_IMAGE_WIDTH, 12'd3);
        // flat frame, vertical edge, horizontal edge
        for (int i = 0; i < 9; i++) push_pixel(8'd0, i == 0);
        for (int i = 0; i < 9; i++) push_pixel((i % 3 == 2) ? 8'hff : 8'h00, i == 0);
        for (int i = 0; i < 9; i++) push_pixel((i < 3) ? 8'hff : 8'h00, i == 0);
        drain();

        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 52; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 52; end
                default: begin tx_idle_pct = 25; rx_stall_pct = 25; end
            endcase
            w = $urandom_range(3, 12);
            h = $urandom_range(3, 8);
            case (ph)
                3: write_reg(CFG_IMAGE_WIDTH, 12'd0);
                5: write_reg(CFG_IMAGE_WIDTH, 12'd2047);
                6: write_reg(CFG_IMAGE_WIDTH, 12'd2);
                default: write_reg(CFG_IMAGE_WIDTH, 12'(w));
            endcase
            case (ph)
                7: write_reg(CFG_IMAGE_HEIGHT, 12'd0);
                9: write_reg(CFG_IMAGE_HEIGHT, 12'd2);
                default: write_reg(CFG_IMAGE_HEIGHT, 12'(h));
            endcase
            if (ph == 5) push_random(60, 20, 0);
            else push_frames(w, h, 32);
            drain();
        end

        // tallest frame, only its top part
        tx_idle_pct = 10;
        rx_stall_pct = 10;
        write_reg(CFG_IMAGE_WIDTH, 12'd3);
        write_reg(CFG_IMAGE_HEIGHT, 12'd4095);
        push_pixel(8'($urandom), 1'b1);
        push_random(99, 30, 0);
        drain();

        // long receiver hold while the sender keeps offering
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        write_reg(CFG_IMAGE_WIDTH, 12'd4);
        write_reg(CFG_IMAGE_HEIGHT, 12'd5);
        @(negedge i_clk);
        rx_hold_cycles = 400;
        push_frames(4, 5, 160);
        drain();

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/sgmd_pkg.sv
rtl/sgmd_front.sv
rtl/sgmd_queue.sv
rtl/sgmd_back.sv
rtl/sobel_gradient_magnitude_direction_core.sv
tb/tb_sobel_gradient_magnitude_direction_core.sv
